// File: hw/rtl/pvss_pkg.sv
// shared types and constants for the pcm voice start register sequencer
// no dependencies; imported by every module of the block
package pvss_pkg;

	localparam int VOICE_SLOTS = 4;

	localparam int ADDR_W  = 20;
	localparam int COUNT_W = 20;
	localparam int RATE_W  = 16;
	localparam int MANT_W  = 10;
	localparam int OCT_W   = 4;
	localparam int WORD_W  = 16;

	// samples must end at or below this byte address (bit index of the limit)
	localparam int PLACE_LIMIT_BIT = 19;

	localparam logic [RATE_W-1:0] NATIVE_RATE = 16'd44100;
	localparam logic [OCT_W-1:0]  MAX_OCTAVE  = 4'd8;

	// register field codes
	localparam logic [3:0] TGT_KEYS    = 4'd0;
	localparam logic [3:0] TGT_ADDR_LO = 4'd1;
	localparam logic [3:0] TGT_LOOP_ST = 4'd2;
	localparam logic [3:0] TGT_LOOP_END = 4'd3;
	localparam logic [3:0] TGT_ENV     = 4'd4;
	localparam logic [3:0] TGT_RELEASE = 4'd5;
	localparam logic [3:0] TGT_ATTEN   = 4'd6;
	localparam logic [3:0] TGT_PITCH   = 4'd7;
	localparam logic [3:0] TGT_PAN_SEND = 4'd8;
	localparam logic [3:0] TGT_MASTER  = 4'd9;

	// status codes
	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_BAD_SLOT  = 2'd1;
	localparam logic [1:0] STS_BAD_PLACE = 2'd2;
	localparam logic [1:0] STS_BAD_RATE  = 2'd3;

	// command codes
	localparam logic [1:0] ACT_START  = 2'd0;
	localparam logic [1:0] ACT_STOP   = 2'd1;
	localparam logic [1:0] ACT_MASTER = 2'd2;

	localparam logic [WORD_W-1:0] KEY_EXEC   = 16'h1000;
	localparam logic [WORD_W-1:0] KEY_ON     = 16'h0800;
	localparam logic [WORD_W-1:0] KEY_PCM8   = 16'h0010;
	localparam logic [WORD_W-1:0] KEY_LOOP   = 16'h0020;
	localparam logic [WORD_W-1:0] MASTER_REG = 16'h0200;
	localparam logic [WORD_W-1:0] ENV_MAX    = 16'd31;

	// handshake between the top level and a serial check unit
	typedef struct packed {
		logic done;
		logic ok;
	} unit_sts_t;

endpackage

// File: hw/rtl/pvss_place.sv
// bit-serial placement check: offset + count must not pass the sample limit
// depends on pvss_pkg
module pvss_place (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pvss_pkg::ADDR_W-1:0]   offset,
	input  logic [pvss_pkg::COUNT_W-1:0]  count,
	output pvss_pkg::unit_sts_t           sts
);
	import pvss_pkg::*;

	localparam int CNT_W = $clog2(ADDR_W);

	logic [ADDR_W-1:0]  a_q;
	logic [COUNT_W-1:0] b_q;
	logic               carry_q;
	logic               nz_q;
	logic               low_nz_q;
	logic [CNT_W-1:0]   bit_q;
	logic               run_q;
	logic               done_q;
	logic               ok_q;

	logic sum_c;
	logic cout_c;
	logic nz_c;

	assign sum_c  = a_q[0] ^ b_q[0] ^ carry_q;
	assign cout_c = (a_q[0] & b_q[0]) | (a_q[0] & carry_q) | (b_q[0] & carry_q);
	assign nz_c   = nz_q | b_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			done_q   <= 1'b0;
			ok_q     <= 1'b0;
			bit_q    <= '0;
			carry_q  <= 1'b0;
			nz_q     <= 1'b0;
			low_nz_q <= 1'b0;
		end else if (start) begin
			run_q    <= 1'b1;
			done_q   <= 1'b0;
			ok_q     <= 1'b0;
			bit_q    <= '0;
			carry_q  <= 1'b0;
			nz_q     <= 1'b0;
			low_nz_q <= 1'b0;
		end else if (run_q) begin
			carry_q <= cout_c;
			nz_q    <= nz_c;
			if (bit_q < CNT_W'(PLACE_LIMIT_BIT)) begin
				low_nz_q <= low_nz_q | sum_c;
			end
			// top sum bit is the carry out of the last position
			if (bit_q == CNT_W'(ADDR_W - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
				ok_q   <= nz_c & ~cout_c & ~(sum_c & low_nz_q);
			end else begin
				bit_q <= bit_q + 1'b1;
			end
		end
	end

	// operand shift registers, lsb first
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= offset;
			b_q <= count;
		end else if (run_q) begin
			a_q <= a_q >> 1;
			b_q <= b_q >> 1;
		end
	end

	assign sts.done = done_q;
	assign sts.ok   = ok_q;

endmodule

// File: hw/rtl/pvss_pitch.sv
// pitch word unit: octave search by halving, then restoring bit-serial divide
// depends on pvss_pkg
module pvss_pitch (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pvss_pkg::RATE_W-1:0]  rate,
	output pvss_pkg::unit_sts_t          sts,
	output logic [pvss_pkg::WORD_W-1:0]  word
);
	import pvss_pkg::*;

	localparam int QUO_W = MANT_W + 1;
	localparam int CNT_W = $clog2(QUO_W);

	typedef enum logic [1:0] {
		P_IDLE,
		P_OCT,
		P_DIV
	} pstate_t;

	pstate_t             state_q;
	logic [RATE_W-1:0]   rate_q;
	logic [RATE_W-1:0]   base_q;
	logic [OCT_W-1:0]    oct_q;
	logic [RATE_W:0]     rem_q;
	logic [QUO_W-1:0]    quo_q;
	logic [CNT_W-1:0]    step_q;
	logic                done_q;
	logic                ok_q;
	logic [WORD_W-1:0]   word_q;

	logic              qbit_c;
	logic [RATE_W:0]   sub_c;
	logic [QUO_W-1:0]  quo_c;
	logic [OCT_W-1:0]  oct_neg_c;

	assign sub_c     = rem_q - {1'b0, base_q};
	assign qbit_c    = ~sub_c[RATE_W];
	assign quo_c     = {quo_q[QUO_W-2:0], qbit_c};
	assign oct_neg_c = OCT_W'(0) - oct_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			done_q  <= 1'b0;
			ok_q    <= 1'b0;
			step_q  <= '0;
			oct_q   <= '0;
		end else if (start) begin
			ok_q   <= 1'b0;
			oct_q  <= '0;
			if (rate == '0 || rate > NATIVE_RATE) begin
				state_q <= P_IDLE;
				done_q  <= 1'b1;
			end else begin
				state_q <= P_OCT;
				done_q  <= 1'b0;
			end
		end else begin
			case (state_q)
				P_OCT: begin
					if (base_q > rate_q && oct_q < MAX_OCTAVE) begin
						oct_q <= oct_q + 1'b1;
					end else if (oct_q == MAX_OCTAVE) begin
						// rate below the lowest octave
						state_q <= P_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= P_DIV;
						step_q  <= '0;
					end
				end
				P_DIV: begin
					if (step_q == CNT_W'(QUO_W - 1)) begin
						state_q <= P_IDLE;
						done_q  <= 1'b1;
						ok_q    <= ~quo_c[QUO_W-1];
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				default: begin
					state_q <= P_IDLE;
				end
			endcase
		end
	end

	// datapath: base halving, remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rate_q <= rate;
			base_q <= NATIVE_RATE;
		end else begin
			case (state_q)
				P_OCT: begin
					if (base_q > rate_q && oct_q < MAX_OCTAVE) begin
						base_q <= base_q >> 1;
					end else begin
						rem_q <= {1'b0, rate_q - base_q};
						quo_q <= '0;
					end
				end
				P_DIV: begin
					rem_q  <= qbit_c ? {sub_c[RATE_W-1:0], 1'b0} : {rem_q[RATE_W-1:0], 1'b0};
					quo_q  <= quo_c;
					// octave in bits 14..11, mantissa in bits 9..0
					word_q <= {1'b0, oct_neg_c, 1'b0, quo_c[MANT_W-1:0]};
				end
				default: begin
					rate_q <= rate_q;
				end
			endcase
		end
	end

	assign sts.done = done_q;
	assign sts.ok   = ok_q;
	assign word     = word_q;

endmodule

// File: hw/rtl/pcm_voice_start_register_sequencer.sv
// top level of the pcm voice start register sequencer
// depends on pvss_pkg, pvss_place and pvss_pitch
//
// Takes one voice command per item (start, stop or master volume) and turns
// it into register writes for an 8-bit pcm sound chip. A stop gives one
// key-execute write, a master command one master write, a rejected command
// one status result, action code three nothing. A start runs two serial units
// side by side: a bit-serial adder that checks the sample lies below the
// half-megabyte limit (one address bit a cycle) and the pitch unit
// (up to 8 halvings for the octave, then an 11-step restoring division, one
// quotient bit a cycle); it then emits ten writes, key word last, one a cycle
// while the output is not stalled. Stop, master and bad-slot rejects give
// their single result directly; placement and rate rejects wait for both
// units. The block works on one command at a time; it takes the next command
// as soon as the final result of the current one sits in the output register.
module pcm_voice_start_register_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  slot,
	input  logic [19:0] ram_offset,
	input  logic [19:0] sample_len,
	input  logic [15:0] play_rate,
	input  logic        loop_enable,
	input  logic [15:0] volume,
	input  logic signed [15:0] pan,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        write_valid,
	output logic [3:0]  target,
	output logic [4:0]  slot_out,
	output logic [15:0] write_value,
	output logic        last,
	output logic [1:0]  status
);
	import pvss_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_ONE,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		ONE_MASTER,
		ONE_STOP,
		ONE_REJECT
	} one_kind_t;

	state_t            state_q;
	one_kind_t         kind_q;
	logic [1:0]        rej_q;
	logic [3:0]        idx_q;

	// captured command fields
	logic [4:0]        slot_q;
	logic [ADDR_W-1:0] offset_q;
	logic [15:0]       loop_end_q;
	logic              loop_q;
	logic [3:0]        vol_q;
	logic [4:0]        pan_code_q;

	// output register
	logic              out_valid_q;
	logic              write_valid_q;
	logic [3:0]        target_q;
	logic [4:0]        slot_out_q;
	logic [15:0]       write_value_q;
	logic              last_q;
	logic [1:0]        status_q;

	unit_sts_t         place_sts;
	unit_sts_t         pitch_sts;
	logic [WORD_W-1:0] pitch_val;

	logic              accept_c;
	logic              start_go_c;
	logic              slot_bad_c;
	logic              load_c;
	logic [3:0]        vol_sat_c;
	logic [4:0]        pan_abs_c;
	logic [5:0]        pan_inc_c;
	logic [3:0]        pan_mag_c;

	// result about to be loaded
	logic              r_wv_c;
	logic [3:0]        r_tgt_c;
	logic [4:0]        r_slot_c;
	logic [15:0]       r_val_c;
	logic              r_last_c;
	logic [1:0]        r_sts_c;

	assign accept_c   = in_valid & ~in_stall;
	assign slot_bad_c = slot >= 8'(VOICE_SLOTS);
	assign start_go_c = accept_c & (action == ACT_START) & ~slot_bad_c;
	assign in_stall   = (state_q != ST_IDLE);
	assign load_c     = ((state_q == ST_ONE) || (state_q == ST_EMIT)) &
	                    (~out_valid_q | ~out_stall);

	// saturations of the send level and the pan
	assign vol_sat_c = (volume > 16'd15) ? 4'hF : volume[3:0];
	always_comb begin
		if (pan < -16'sd31 || pan > 16'sd31) begin
			pan_abs_c = 5'd31;
		end else if (pan[15]) begin
			pan_abs_c = 5'(-pan);
		end else begin
			pan_abs_c = pan[4:0];
		end
		pan_inc_c = (6'(pan_abs_c) + 6'd1) >> 1;
		pan_mag_c = pan_inc_c[5:4] != 2'b00 ? 4'hF : pan_inc_c[3:0];
	end

	pvss_place u_place (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_go_c),
		.offset (ram_offset),
		.count  (sample_len),
		.sts    (place_sts)
	);

	pvss_pitch u_pitch (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_go_c),
		.rate   (play_rate),
		.sts    (pitch_sts),
		.word   (pitch_val)
	);

	// result selection
	always_comb begin
		r_wv_c   = 1'b1;
		r_tgt_c  = TGT_KEYS;
		r_slot_c = slot_q;
		r_val_c  = '0;
		r_last_c = 1'b0;
		r_sts_c  = STS_OK;
		if (state_q == ST_ONE) begin
			r_last_c = 1'b1;
			case (kind_q)
				ONE_MASTER: begin
					r_tgt_c  = TGT_MASTER;
					r_slot_c = '0;
					r_val_c  = MASTER_REG | 16'(vol_q);
				end
				ONE_STOP: begin
					r_val_c = KEY_EXEC;
				end
				default: begin
					r_wv_c   = 1'b0;
					r_slot_c = '0;
					r_sts_c  = rej_q;
				end
			endcase
		end else begin
			case (idx_q)
				4'd0: begin
					r_tgt_c = TGT_KEYS;
					r_val_c = KEY_EXEC;
				end
				4'd1: begin
					r_tgt_c = TGT_ADDR_LO;
					r_val_c = offset_q[15:0];
				end
				4'd2: r_tgt_c = TGT_LOOP_ST;
				4'd3: begin
					r_tgt_c = TGT_LOOP_END;
					r_val_c = loop_end_q;
				end
				4'd4: begin
					r_tgt_c = TGT_ENV;
					r_val_c = ENV_MAX;
				end
				4'd5: begin
					r_tgt_c = TGT_RELEASE;
					r_val_c = ENV_MAX;
				end
				4'd6: r_tgt_c = TGT_ATTEN;
				4'd7: begin
					r_tgt_c = TGT_PITCH;
					r_val_c = pitch_val;
				end
				4'd8: begin
					r_tgt_c = TGT_PAN_SEND;
					r_val_c = {vol_q[3:1], pan_code_q, 8'd0};
				end
				default: begin
					// key word closes the sequence
					r_tgt_c  = TGT_KEYS;
					r_val_c  = KEY_EXEC | KEY_ON | KEY_PCM8 | 16'(offset_q[19:16]) |
					           (loop_q ? KEY_LOOP : 16'd0);
					r_last_c = 1'b1;
				end
			endcase
		end
	end

	// command sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= ONE_MASTER;
			rej_q       <= STS_OK;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_c) begin
				out_valid_q <= 1'b1;
			end else if (~out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept_c) begin
						idx_q <= '0;
						case (action)
							ACT_MASTER: begin
								kind_q  <= ONE_MASTER;
								state_q <= ST_ONE;
							end
							ACT_STOP: begin
								kind_q  <= slot_bad_c ? ONE_REJECT : ONE_STOP;
								rej_q   <= STS_BAD_SLOT;
								state_q <= ST_ONE;
							end
							ACT_START: begin
								if (slot_bad_c) begin
									kind_q  <= ONE_REJECT;
									rej_q   <= STS_BAD_SLOT;
									state_q <= ST_ONE;
								end else begin
									state_q <= ST_CALC;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CALC: begin
					if (place_sts.done && pitch_sts.done) begin
						if (!place_sts.ok) begin
							kind_q  <= ONE_REJECT;
							rej_q   <= STS_BAD_PLACE;
							state_q <= ST_ONE;
						end else if (!pitch_sts.ok) begin
							kind_q  <= ONE_REJECT;
							rej_q   <= STS_BAD_RATE;
							state_q <= ST_ONE;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_ONE: begin
					if (load_c) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (load_c) begin
						if (r_last_c) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// command payload capture
	always_ff @(posedge clk) begin
		if (accept_c) begin
			slot_q     <= slot[4:0];
			offset_q   <= ram_offset;
			loop_end_q <= sample_len[15:0] - 16'd1;
			loop_q     <= loop_enable;
			vol_q      <= vol_sat_c;
			pan_code_q <= {pan[15], pan_mag_c};
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (load_c) begin
			write_valid_q <= r_wv_c;
			target_q      <= r_tgt_c;
			slot_out_q    <= r_slot_c;
			write_value_q <= r_val_c;
			last_q        <= r_last_c;
			status_q      <= r_sts_c;
		end
	end

	assign out_valid   = out_valid_q;
	assign write_valid = write_valid_q;
	assign target      = target_q;
	assign slot_out    = slot_out_q;
	assign write_value = write_value_q;
	assign last        = last_q;
	assign status      = status_q;

`ifndef SYNTHESIS
	// a register write never carries a failure status
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_valid |-> status == STS_OK)
		else $error("write result with nonzero status");

	// status results always close their command
	a_reject_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_valid |-> last && status != STS_OK)
		else $error("status result not final or status ok");

	// master writes never name a slot
	a_master_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_valid && target == TGT_MASTER |-> slot_out == 5'd0)
		else $error("master write with a slot");

	// a command that yields results blocks the input on the next cycle
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (action == ACT_START || action == ACT_STOP ||
		action == ACT_MASTER) |=> in_stall)
		else $error("input not held off after a command");
`endif

endmodule
